// File: sv/ipid_pkg.sv
// Shared types and constants for the two-channel incremental PID core.
package ipid_pkg;

    localparam int NUM_CH    = 2;
    localparam int CH_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;

    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int ACC_W     = 32;
    localparam int DRIVE_W   = 11;
    localparam int DRIVE_LIM = 1000;
    localparam int FRAC_BITS = 12;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = GAIN_W'(532);
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = GAIN_W'(410);
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = GAIN_W'(410);

    typedef enum logic [ADDR_W-3:0] {
        REG_GAIN_PROP  = 2'd0,
        REG_GAIN_INTEG = 2'd1,
        REG_GAIN_DERIV = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

endpackage

// File: sv/ipid_if.sv
// Handshake interfaces for the input item and result channels.
interface ipid_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 channel;
    logic signed [ipid_pkg::SPEED_W-1:0]  target_speed;
    logic signed [ipid_pkg::SPEED_W-1:0]  measured_speed;

    modport source (output valid, channel, target_speed, measured_speed, input ready);
    modport sink   (input valid, channel, target_speed, measured_speed, output ready);
endinterface

interface ipid_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ipid_pkg::DRIVE_W-1:0]  drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

// File: sv/ipid_cfg.sv
// APB-style gain register bank.
module ipid_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipid_pkg::DATA_W-1:0]  pwdata,
    output logic [ipid_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ipid_pkg::t_gains             o_gains
);
    import ipid_pkg::*;

    t_gains   r_gains;
    t_gains   n_gains;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_gains = r_gains;

    always_comb begin
        n_gains = r_gains;
        prdata  = '0;
        case (reg_idx)
            REG_GAIN_PROP: begin
                prdata = DATA_W'(r_gains.prop);
                if (wr_en) n_gains.prop = pwdata[GAIN_W-1:0];
            end
            REG_GAIN_INTEG: begin
                prdata = DATA_W'(r_gains.integ);
                if (wr_en) n_gains.integ = pwdata[GAIN_W-1:0];
            end
            REG_GAIN_DERIV: begin
                prdata = DATA_W'(r_gains.deriv);
                if (wr_en) n_gains.deriv = pwdata[GAIN_W-1:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= GAIN_PROP_RST;
            r_gains.integ <= GAIN_INTEG_RST;
            r_gains.deriv <= GAIN_DERIV_RST;
        end else begin
            r_gains <= n_gains;
        end
    end

endmodule

// File: sv/ipid_calc.sv
// Velocity-form PID arithmetic: increment, saturating accumulate, drive clamp.
module ipid_calc (
    input  ipid_pkg::t_gains                    i_gains,
    input  logic signed [ipid_pkg::SPEED_W-1:0] i_target,
    input  logic signed [ipid_pkg::SPEED_W-1:0] i_measured,
    input  logic signed [ipid_pkg::ERR_W-1:0]   i_last_err,
    input  logic signed [ipid_pkg::ERR_W-1:0]   i_prior_err,
    input  logic signed [ipid_pkg::ACC_W-1:0]   i_acc,
    output logic signed [ipid_pkg::ERR_W-1:0]   o_err,
    output logic signed [ipid_pkg::ERR_W-1:0]   o_prior_next,
    output logic signed [ipid_pkg::ACC_W-1:0]   o_acc,
    output logic signed [ipid_pkg::DRIVE_W-1:0] o_drive
);
    import ipid_pkg::*;

    localparam int D1_W  = ERR_W + 1;
    localparam int D2_W  = ERR_W + 2;
    localparam int GS_W  = GAIN_W + 1;
    localparam int SUM_W = GS_W + D2_W + 2;
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;

    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(DRIVE_LIM);
    localparam logic signed [ACC_W-1:0] LIM_LO = -ACC_W'(DRIVE_LIM);

    logic                            hist_clr;
    logic signed [ERR_W-1:0]         e1;
    logic signed [ERR_W-1:0]         e2;
    logic signed [D1_W-1:0]          d1;
    logic signed [D2_W-1:0]          d2;
    logic signed [GS_W-1:0]          kp;
    logic signed [GS_W-1:0]          ki;
    logic signed [GS_W-1:0]          kd;
    logic signed [GS_W+D1_W-1:0]     p_prop;
    logic signed [GS_W+ERR_W-1:0]    p_integ;
    logic signed [GS_W+D2_W-1:0]     p_deriv;
    logic signed [SUM_W-1:0]         sum;
    logic signed [SUM_W-1:0]         bias;
    logic signed [SUM_W-1:0]         inc;
    logic signed [SUM_W-1:0]         acc_sum;
    logic [SUM_W-ACC_W:0]            acc_top;
    logic                            acc_ovf;

    // zero measured speed wipes the history before it is used
    assign hist_clr = (i_measured == '0);
    assign e1       = hist_clr ? '0 : i_last_err;
    assign e2       = hist_clr ? '0 : i_prior_err;

    assign o_err        = ERR_W'(i_measured) - ERR_W'(i_target);
    assign o_prior_next = e1;

    assign d1 = D1_W'(o_err) - D1_W'(e1);
    assign d2 = D2_W'(o_err) - (D2_W'(e1) <<< 1) + D2_W'(e2);

    assign kp = $signed({1'b0, i_gains.prop});
    assign ki = $signed({1'b0, i_gains.integ});
    assign kd = $signed({1'b0, i_gains.deriv});

    assign p_prop  = kp * d1;
    assign p_integ = ki * o_err;
    assign p_deriv = kd * d2;

    assign sum = SUM_W'(p_prop) + SUM_W'(p_integ) + SUM_W'(p_deriv);

    // truncate toward zero: bias negatives by one less than the scale
    assign bias = sum[SUM_W-1] ? SUM_W'(FRAC_MASK) : '0;
    assign inc  = (sum + bias) >>> FRAC_BITS;

    assign acc_sum = SUM_W'(i_acc) + inc;
    assign acc_top = acc_sum[SUM_W-1:ACC_W-1];
    assign acc_ovf = !((&acc_top) || !(|acc_top));

    always_comb begin
        if (acc_ovf) begin
            o_acc = {acc_sum[SUM_W-1], {(ACC_W-1){~acc_sum[SUM_W-1]}}};
        end else begin
            o_acc = acc_sum[ACC_W-1:0];
        end
        if (o_acc > LIM_HI) begin
            o_drive = DRIVE_W'(LIM_HI);
        end else if (o_acc < LIM_LO) begin
            o_drive = DRIVE_W'(LIM_LO);
        end else begin
            o_drive = o_acc[DRIVE_W-1:0];
        end
    end

endmodule

// File: sv/incremental_pid_two_channel_core.sv
// Top level of the two-channel incremental PID core: item register, state, result register.
// Two-channel velocity-form PID with shared Q4.12 gains. Each item gives a channel, target
// and measured speed; the error is measured minus target, and a measured speed of zero
// clears that channel's error history first. The increment kp*(e-e1) + ki*e +
// kd*(e-2e1+e2), truncated toward zero, is added to the channel's 32-bit saturating
// accumulator and the result item carries that accumulator clamped to +-1000. The core
// takes one item per clock while results drain: the item is held in an input register,
// the whole update is worked out combinationally from there, and the per-channel state is
// written as the result moves into the output register, from which it is offered; a
// following item on the same channel sees the updated state. The output register lets a
// new item enter while a result still waits. Gains are written over the APB port at byte
// addresses 0, 4 and 8; the user must do so only while the core is idle (not enforced).
module incremental_pid_two_channel_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ipid_item_if.sink                    i_item,
    ipid_res_if.source                   o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipid_pkg::DATA_W-1:0]  pwdata,
    output logic [ipid_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import ipid_pkg::*;

    t_gains                     gains;

    logic                       r_s1_valid;
    logic                       r_s1_channel;
    logic signed [SPEED_W-1:0]  r_s1_target;
    logic signed [SPEED_W-1:0]  r_s1_measured;

    logic                       r_out_valid;
    logic signed [DRIVE_W-1:0]  r_out_drive;

    logic signed [ERR_W-1:0]    r_last_err  [NUM_CH];
    logic signed [ERR_W-1:0]    r_prior_err [NUM_CH];
    logic signed [ACC_W-1:0]    r_acc       [NUM_CH];

    logic [CH_W-1:0]            s1_ch;
    logic                       adv;
    logic                       take;
    logic signed [ERR_W-1:0]    calc_err;
    logic signed [ERR_W-1:0]    calc_prior;
    logic signed [ACC_W-1:0]    calc_acc;
    logic signed [DRIVE_W-1:0]  calc_drive;

    ipid_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gains (gains)
    );

    assign s1_ch = (NUM_CH == 1) ? '0 : CH_W'(r_s1_channel);

    ipid_calc u_calc (
        .i_gains      (gains),
        .i_target     (r_s1_target),
        .i_measured   (r_s1_measured),
        .i_last_err   (r_last_err[s1_ch]),
        .i_prior_err  (r_prior_err[s1_ch]),
        .i_acc        (r_acc[s1_ch]),
        .o_err        (calc_err),
        .o_prior_next (calc_prior),
        .o_acc        (calc_acc),
        .o_drive      (calc_drive)
    );

    // stage 1 moves on when the output register is free or being drained
    assign adv  = r_s1_valid && (!r_out_valid || o_result.ready);
    assign take = i_item.valid && i_item.ready;

    assign i_item.ready    = !r_s1_valid || adv;
    assign o_result.valid  = r_out_valid;
    assign o_result.drive  = r_out_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_channel  <= i_item.channel;
            r_s1_target   <= i_item.target_speed;
            r_s1_measured <= i_item.measured_speed;
        end
        if (adv) begin
            r_out_drive <= calc_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CH; i++) begin
                r_last_err[i]  <= '0;
                r_prior_err[i] <= '0;
                r_acc[i]       <= '0;
            end
        end else if (adv) begin
            r_last_err[s1_ch]  <= calc_err;
            r_prior_err[s1_ch] <= calc_prior;
            r_acc[s1_ch]       <= calc_acc;
        end
    end

`ifndef SYNTHESIS
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.drive <= DRIVE_W'(DRIVE_LIM))
                        && (o_result.drive >= -DRIVE_W'(DRIVE_LIM)))
        else $error("drive outside clamp range");

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_result.valid)
        else $error("finished item did not reach the output register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> (r_s1_valid && r_out_valid && !o_result.ready))
        else $error("input stalled without a blocked output");

    a_hist_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_last_err[$past(s1_ch)] == $past(calc_err))
             && (r_prior_err[$past(s1_ch)] == $past(calc_prior)))
        else $error("channel error history not updated");
`endif

endmodule

// File: verif/tb_incremental_pid_two_channel_core.sv
// Self-checking testbench for the two-channel incremental PID core: directed, random and stress.
module tb_incremental_pid_two_channel_core;
    import ipid_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_OFF_LEN = 64;
    localparam int SAT_RUN      = 20;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 92;
    localparam int REPORT_CAP   = 20;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [ADDR_W-3:0] REG_UNMAPPED = 2'd3;

    localparam longint FRAC_ONE = longint'(1) <<< FRAC_BITS;
    localparam longint ACC_HI   = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO   = -(longint'(1) <<< (ACC_W - 1));

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic        [GAIN_W-1:0]  GAIN_MAX  = '1;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    ipid_item_if item_bus();
    ipid_res_if  res_bus();

    incremental_pid_two_channel_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (res_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor copy of gains and per-channel loop state
    t_gains                   gains_m;
    logic signed [ERR_W-1:0]  last_err_m  [NUM_CH];
    logic signed [ERR_W-1:0]  prior_err_m [NUM_CH];
    logic signed [ACC_W-1:0]  acc_m       [NUM_CH];

    logic signed [DRIVE_W-1:0] pending_drive_q [$];
    logic signed [DRIVE_W-1:0] want_drive;

    int fail_count     = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int idle_cycles    = 0;
    int hold_off_req   = 0;
    bit send_gaps_on   = 1'b1;
    bit recv_stalls_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < REPORT_CAP) $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // One velocity-form update; returns the clamped drive and advances the channel state.
    function automatic logic signed [DRIVE_W-1:0] pid_update(
        input logic                      ch,
        input logic signed [SPEED_W-1:0] tgt,
        input logic signed [SPEED_W-1:0] meas
    );
        longint err, e1, e2, weighted, incr, acc_next, clamped;
        err = longint'(meas) - longint'(tgt);
        if (meas == 0) begin
            last_err_m[ch]  = '0;
            prior_err_m[ch] = '0;
        end
        e1 = longint'(last_err_m[ch]);
        e2 = longint'(prior_err_m[ch]);
        weighted = longint'(gains_m.prop)  * (err - e1)
                 + longint'(gains_m.integ) * err
                 + longint'(gains_m.deriv) * (err - 2 * e1 + e2);
        incr = weighted / FRAC_ONE;     // truncates toward zero
        acc_next = longint'(acc_m[ch]) + incr;
        if (acc_next > ACC_HI)
            acc_next = ACC_HI;
        else if (acc_next < ACC_LO)
            acc_next = ACC_LO;
        acc_m[ch]       = ACC_W'(acc_next);
        prior_err_m[ch] = ERR_W'(e1);
        last_err_m[ch]  = ERR_W'(err);
        clamped = acc_next;
        if (clamped > DRIVE_LIM)
            clamped = DRIVE_LIM;
        else if (clamped < -DRIVE_LIM)
            clamped = -DRIVE_LIM;
        return DRIVE_W'(clamped);
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_speed();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return SPEED_W'(int'($urandom_range(0, 128)) - 64);
        if (pick < 60) begin
            case ($urandom_range(0, 3))
                0:       return SPEED_MIN;
                1:       return SPEED_MAX;
                2:       return -1;
                default: return 1;
            endcase
        end
        return SPEED_W'($urandom());
    endfunction

    // valid stays high across back-to-back items; this task lowers it only when a gap is drawn
    task automatic send_item(
        input logic                      ch,
        input logic signed [SPEED_W-1:0] tgt,
        input logic signed [SPEED_W-1:0] meas
    );
        int gap;
        gap = send_gaps_on ? int'($urandom_range(0, 15)) : 0;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid          <= 1'b1;
        item_bus.channel        <= ch;
        item_bus.target_speed   <= tgt;
        item_bus.measured_speed <= meas;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        pending_drive_q.push_back(pid_update(ch, tgt, meas));
        items_sent++;
    endtask

    task automatic quiesce();
        item_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-3:0] idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_GAIN_PROP:  gains_m.prop  = data[GAIN_W-1:0];
            REG_GAIN_INTEG: gains_m.integ = data[GAIN_W-1:0];
            REG_GAIN_DERIV: gains_m.deriv = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_read(input logic [ADDR_W-3:0] idx, output logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_all_gains();
        logic [DATA_W-1:0] rd;
        logic [GAIN_W-1:0] want;
        t_reg_idx          idx;
        for (int r = 0; r < 3; r++) begin
            idx = t_reg_idx'(r);
            case (idx)
                REG_GAIN_PROP:  want = gains_m.prop;
                REG_GAIN_INTEG: want = gains_m.integ;
                default:        want = gains_m.deriv;
            endcase
            apb_read(idx, rd);
            if (rd[GAIN_W-1:0] !== want)
                report_mismatch($sformatf("gain %s reads %0d, written %0d",
                                          idx.name(), rd[GAIN_W-1:0], want));
        end
    endtask

    // upper data bits are junk on purpose: only the low 16 bits belong to a gain
    task automatic set_gains(
        input logic [GAIN_W-1:0] prop,
        input logic [GAIN_W-1:0] integ,
        input logic [GAIN_W-1:0] deriv
    );
        apb_write(REG_GAIN_PROP,  {GAIN_W'($urandom()), prop});
        apb_write(REG_GAIN_INTEG, {GAIN_W'($urandom()), integ});
        apb_write(REG_GAIN_DERIV, {GAIN_W'($urandom()), deriv});
        check_all_gains();
        settings_used++;
    endtask

    task automatic test_register_access();
        check_all_gains();
        apb_write(REG_UNMAPPED, $urandom());
        check_all_gains();
        set_gains(GAIN_MAX, '0, 16'h5a5a);
        set_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST);
    endtask

    task automatic test_directed();
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        send_item(1'b0, 16'sd0, 16'sd0);        // clear with empty history
        send_item(1'b0, SPEED_MIN, SPEED_MAX);  // largest positive error
        send_item(1'b0, SPEED_MAX, SPEED_MIN);  // largest negative error
        send_item(1'b0, SPEED_MAX, SPEED_MIN);
        send_item(1'b0, 16'sd300, 16'sd0);      // history cleared, accumulator kept
        send_item(1'b1, 16'sd10, 16'sd12);
        send_item(1'b1, 16'sd10, 16'sd11);
        send_item(1'b1, 16'sd10, 16'sd9);
        send_item(1'b1, 16'sd10, 16'sd10);
        send_item(1'b1, SPEED_MIN, SPEED_MIN);
        send_item(1'b1, SPEED_MAX, SPEED_MAX);
        send_item(1'b0, -16'sd1, 16'sd1);
        send_item(1'b1, 16'sd1, -16'sd1);       // negative sum, truncation toward zero
        send_item(1'b1, SPEED_MAX, 16'sd0);
        send_item(1'b1, SPEED_MIN, 16'sd0);
        quiesce();
        set_gains('0, '0, '0);
        send_item(1'b0, SPEED_MIN, SPEED_MAX);
        send_item(1'b1, 16'sd5, -16'sd5);
        quiesce();
        set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        send_item(1'b0, 16'sd0, 16'sd1);
        send_item(1'b0, 16'sd0, -16'sd1);
        send_item(1'b1, 16'sd3, -16'sd2);
        send_item(1'b1, -16'sd3, 16'sd2);
        quiesce();
        set_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST);
    endtask

    // result side held off while items keep coming, so the core fills and drops ready
    task automatic test_backpressure();
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        hold_off_req   = HOLD_OFF_LEN;
        repeat (24) send_item(1'($urandom_range(0, 1)), random_speed(), random_speed());
        quiesce();
    endtask

    task automatic test_random();
        logic signed [SPEED_W-1:0] tgt, meas;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: set_gains(GAIN_PROP_RST, GAIN_INTEG_RST, GAIN_DERIV_RST);
                1: set_gains(GAIN_W'($urandom()), GAIN_W'($urandom()), GAIN_W'($urandom()));
                2: set_gains(GAIN_W'($urandom_range(0, 1023)), GAIN_W'($urandom_range(0, 1023)),
                             GAIN_W'($urandom_range(0, 1023)));
                3: set_gains(GAIN_MAX, '0, GAIN_MAX);
                default: set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) begin
                    send_gaps_on   = 1'($urandom_range(0, 1));
                    recv_stalls_on = 1'($urandom_range(0, 1));
                end
                if ($urandom_range(0, 39) == 0) quiesce();
                tgt  = random_speed();
                meas = ($urandom_range(0, 99) < 12) ? SPEED_W'(0) : random_speed();
                send_item(1'($urandom_range(0, 1)), tgt, meas);
            end
            quiesce();
        end
    endtask

    // integral-only drive far past the +-1000 clamp on both channels, then a step back off each
    task automatic test_saturation();
        set_gains('0, GAIN_MAX, '0);
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        for (int n = 0; n < SAT_RUN; n++) begin
            send_item(1'b0, SPEED_MIN, SPEED_MAX);
            send_item(1'b1, SPEED_MAX, SPEED_MIN);
        end
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        repeat (3) begin
            send_item(1'b0, SPEED_MAX, SPEED_MIN);
            send_item(1'b1, SPEED_MIN, SPEED_MAX);
        end
        quiesce();
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_off_req > 0) begin
                stall        = hold_off_req;
                hold_off_req = 0;
            end else begin
                stall = recv_stalls_on ? int'($urandom_range(0, 15)) : 0;
            end
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            results_seen++;
            if (pending_drive_q.size() == 0) begin
                report_mismatch($sformatf("drive %0d with no item outstanding", res_bus.drive));
            end else begin
                want_drive = pending_drive_q.pop_front();
                if (res_bus.drive !== want_drive)
                    report_mismatch($sformatf("drive %0d, predicted %0d",
                                              res_bus.drive, want_drive));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_drive_q.size());
            $display("incremental_pid_two_channel_core regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n                 <= 1'b0;
        item_bus.valid          <= 1'b0;
        item_bus.channel        <= 1'b0;
        item_bus.target_speed   <= '0;
        item_bus.measured_speed <= '0;
        res_bus.ready           <= 1'b0;
        psel                    <= 1'b0;
        penable                 <= 1'b0;
        pwrite                  <= 1'b0;
        paddr                   <= '0;
        pwdata                  <= '0;
        gains_m     = '{prop: GAIN_PROP_RST, integ: GAIN_INTEG_RST, deriv: GAIN_DERIV_RST};
        last_err_m  = '{default: '0};
        prior_err_m = '{default: '0};
        acc_m       = '{default: '0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed();
        test_backpressure();
        test_random();
        test_saturation();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_drive_q.size() != 0)
            report_mismatch($sformatf("%0d drive results never arrived",
                                      pending_drive_q.size()));
        $display("covered %0d items and %0d results over %0d gain settings on both channels",
                 items_sent, results_seen, settings_used);
        $display("incl. history clears, +-1000 clamping, gain extremes and output hold-off");
        if (fail_count == 0)
            $display("incremental_pid_two_channel_core regression: pass");
        else
            $display("incremental_pid_two_channel_core regression: fail");
        $finish;
    end

endmodule
